@@ hdl/upd_pkg.sv @@
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character codes and character-class functions for the URL
// percent decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DIG_LO  = 8'd48;
    localparam logic [7:0] CH_DIG_HI  = 8'd57;
    localparam logic [7:0] CH_LOW_LO  = 8'd97;
    localparam logic [7:0] CH_LOW_HI  = 8'd122;
    localparam logic [7:0] CH_UP_LO   = 8'd65;
    localparam logic [7:0] CH_UP_HI   = 8'd90;
    localparam logic [7:0] CH_LOW_F   = 8'd102;
    localparam logic [7:0] CH_UP_F    = 8'd70;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_DIG  = 2'd2
    } t_phase;

    // results of one item: up to three bytes, in order from data[0]
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] data;
        logic            last;
    } t_group;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_DIG_LO && c <= CH_DIG_HI) ||
               (c >= CH_LOW_LO && c <= CH_LOW_F) ||
               (c >= CH_UP_LO && c <= CH_UP_F);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CH_DIG_LO && c <= CH_DIG_HI) begin
            v = c - CH_DIG_LO;
        end else if (c >= CH_LOW_LO && c <= CH_LOW_F) begin
            v = c - CH_LOW_LO + 8'd10;
        end else if (c >= CH_UP_LO && c <= CH_UP_F) begin
            v = c - CH_UP_LO + 8'd10;
        end
        return v[3:0];
    endfunction

    function automatic logic is_url_safe(input logic [7:0] v);
        return (v >= CH_DIG_LO && v <= CH_DIG_HI) ||
               (v >= CH_LOW_LO && v <= CH_LOW_HI) ||
               (v >= CH_UP_LO && v <= CH_UP_HI) ||
               (v == 8'h21) || (v == 8'h24) ||
               (v >= 8'h26 && v <= 8'h2F) ||
               (v == 8'h3A) || (v == 8'h3B) || (v == 8'h3D) || (v == 8'h3F) ||
               (v == 8'h40) || (v == 8'h5F);
    endfunction

endpackage

`default_nettype wire

@@ hdl/upd_if.sv @@
// ----------------------------------------------------------------------------
// upd_if
// Valid/ready channels for encoded input bytes and decoded output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

@@ hdl/upd_in_stage.sv @@
// ----------------------------------------------------------------------------
// upd_in_stage
// Input register: holds one accepted transaction until the decoder takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_in_stage (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    upd_in_if.sink     i_in,
    input  wire logic  i_take,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       accept;

    assign i_in.ready = i_rst_n && (!r_valid || i_take);
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_in.in_byte;
            r_last <= i_in.in_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

`default_nettype wire

@@ hdl/upd_decode.sv @@
// ----------------------------------------------------------------------------
// upd_decode
// Escape state and decode logic: turns one byte into up to three results.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_decode (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    input  wire logic        i_take,
    output upd_pkg::t_group  o_group
);

    upd_pkg::t_phase r_phase;
    upd_pkg::t_phase n_phase;
    logic [7:0]      r_held;
    logic [7:0]      n_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= upd_pkg::PH_IDLE;
            r_held  <= 8'd0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    always_comb begin
        logic            fresh;
        logic [1:0]      n;
        logic [2:0][7:0] d;
        logic [7:0]      v;
        fresh   = 1'b1;
        n       = 2'd0;
        d       = '0;
        v       = {upd_pkg::hex_value(r_held), upd_pkg::hex_value(i_byte)};
        n_phase = r_phase;
        n_held  = r_held;

        unique case (r_phase)
            upd_pkg::PH_DIG: begin
                if (upd_pkg::is_hex(i_byte)) begin
                    if (upd_pkg::is_url_safe(v)) begin
                        d[0] = upd_pkg::CH_PERCENT;
                        d[1] = r_held;
                        d[2] = i_byte;
                        n    = 2'd3;
                    end else begin
                        d[0] = v;
                        n    = 2'd1;
                    end
                    fresh = 1'b0;
                end else begin
                    d[0] = upd_pkg::CH_PERCENT;
                    d[1] = r_held;
                    n    = 2'd2;
                end
                n_phase = upd_pkg::PH_IDLE;
            end
            upd_pkg::PH_PCT: begin
                if (upd_pkg::is_hex(i_byte)) begin
                    n_held  = i_byte;
                    n_phase = upd_pkg::PH_DIG;
                    fresh   = 1'b0;
                end else begin
                    d[0]    = upd_pkg::CH_PERCENT;
                    n       = 2'd1;
                    n_phase = upd_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = upd_pkg::PH_IDLE;
            end
        endcase

        if (fresh) begin
            if (i_byte == upd_pkg::CH_PERCENT) begin
                n_phase = upd_pkg::PH_PCT;
            end else if (i_byte == upd_pkg::CH_PLUS) begin
                d[n] = upd_pkg::CH_SPACE;
                n    = n + 2'd1;
            end else begin
                d[n] = i_byte;
                n    = n + 2'd1;
            end
        end

        // end of string flushes a pending escape literally
        if (i_last) begin
            if (n_phase == upd_pkg::PH_PCT) begin
                d[n] = upd_pkg::CH_PERCENT;
                n    = n + 2'd1;
            end else if (n_phase == upd_pkg::PH_DIG) begin
                d[n] = upd_pkg::CH_PERCENT;
                n    = n + 2'd1;
                d[n] = n_held;
                n    = n + 2'd1;
            end
            n_phase = upd_pkg::PH_IDLE;
        end

        o_group.cnt  = n;
        o_group.data = d;
        o_group.last = i_last;
    end

endmodule

`default_nettype wire

@@ hdl/upd_serializer.sv @@
// ----------------------------------------------------------------------------
// upd_serializer
// Result register: holds up to three decoded bytes and sends one per
// transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_serializer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire upd_pkg::t_group i_group,
    output logic                 o_can_load,
    upd_out_if.source            o_out
);

    logic [1:0]      r_cnt;
    logic [2:0][7:0] r_data;
    logic            r_last;
    logic            pop;

    assign pop        = (r_cnt != 2'd0) && o_out.ready;
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_group.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_group.data;
            r_last <= i_group.last;
        end else if (pop) begin
            r_data <= {8'd0, r_data[2], r_data[1]};
        end
    end

    assign o_out.valid    = r_cnt != 2'd0;
    assign o_out.out_byte = r_data[0];
    assign o_out.out_last = r_last && (r_cnt == 2'd1);

endmodule

`default_nettype wire

@@ hdl/url_percent_decoder_unit.sv @@
// Path: an accepted input byte is registered in the input stage, then decoded
// into the result register, which then offers the first decoded byte.
// Throughput: one input byte per cycle while the output is ready and each
// byte yields at most one result; a byte with more results holds the input
// until the result register, sending one byte per transaction, is on its last.
// Reset (synchronous, active low) clears the escape state and empties both registers.
// ----------------------------------------------------------------------------
// url_percent_decoder_unit
// URL percent decoder: '+' to space, %XX to its byte when not URL-safe.
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_decoder_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    upd_in_if.sink    i_in,
    upd_out_if.source o_out
);

    logic            stg_valid;
    logic [7:0]      stg_byte;
    logic            stg_last;
    logic            take;
    logic            can_load;
    upd_pkg::t_group group;

    assign take = stg_valid && can_load;

    upd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (stg_valid),
        .o_byte  (stg_byte),
        .o_last  (stg_last)
    );

    upd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (stg_byte),
        .i_last  (stg_last),
        .i_take  (take),
        .o_group (group)
    );

    upd_serializer u_serializer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_group    (group),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
